// ----- design/pvfm_pkg.sv -----
// shared constants, register codes and stage types of the pv bus voltage fault monitor
package pvfm_pkg;

    // number of pv sample lanes
    localparam int PV_CHANNELS = 4;
    localparam int VOLT_W      = 16;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 3;

    // stream word widths, rounded up to whole bytes
    localparam int IN_DATA_W   = (((PV_CHANNELS + 1) * VOLT_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 3 + VOLT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // debounce limits
    localparam logic [1:0] LOW_HIGH_TRIP = 2'd2;
    localparam logic [7:0] NORMAL_CLEAR  = 8'd250;
    localparam logic [6:0] BUS_TRIP      = 7'd100;

    // request kinds carried in tuser
    localparam logic REQ_PV  = 1'b0;
    localparam logic REQ_BUS = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PV_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PV_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PV_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_LOW  = 3'd3;

    // reset values of the configuration registers
    localparam logic [CNT_W-1:0]  PV_COUNT_RST = 3'd4;
    localparam logic [VOLT_W-1:0] PV_LOW_RST   = 16'h0000;
    localparam logic [VOLT_W-1:0] PV_HIGH_RST  = 16'hFFFF;
    localparam logic [VOLT_W-1:0] BUS_LOW_RST  = 16'h0000;

    // limit registers seen by the merge stage
    typedef struct packed {
        logic [VOLT_W-1:0] pv_low;
        logic [VOLT_W-1:0] pv_high;
        logic [VOLT_W-1:0] bus_low;
    } t_limits;

    // sideband of the lane stage
    typedef struct packed {
        logic              valid;
        logic              req_type;
        logic [VOLT_W-1:0] bus_volt;
    } t_stage;

endpackage

// ----- design/pvfm_lane.sv -----
// one pv sample lane: drops channels beyond the count and registers the sample
module pvfm_lane (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic                   i_enable,
    input  logic [pvfm_pkg::VOLT_W-1:0] i_sample,
    output logic [pvfm_pkg::VOLT_W-1:0] o_value
);
    import pvfm_pkg::*;

    logic [VOLT_W-1:0] r_value;
    logic [VOLT_W-1:0] n_value;

    // unused channels count as zero in the maximum
    always_comb begin
        n_value = i_enable ? i_sample : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ----- design/pvfm_merge.sv -----
// merge stage: maximum over the lanes, debounce counters, fault flags and output word
module pvfm_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pvfm_pkg::t_stage                  i_stage,
    input  logic [pvfm_pkg::PV_CHANNELS-1:0][pvfm_pkg::VOLT_W-1:0] i_lane_value,
    input  pvfm_pkg::t_limits                 i_limits,
    input  logic                              i_m_tready,
    output logic                              o_take,
    output logic                              o_m_tvalid,
    output logic [pvfm_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import pvfm_pkg::*;

    logic [1:0]            r_low_count;
    logic [1:0]            r_high_count;
    logic [7:0]            r_normal_count;
    logic [6:0]            r_bus_count;
    logic                  r_pv_low_fault;
    logic                  r_pv_high_fault;
    logic                  r_bus_low_fault;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [1:0]            n_low_count;
    logic [1:0]            n_high_count;
    logic [7:0]            n_normal_count;
    logic [6:0]            n_bus_count;
    logic                  n_pv_low_fault;
    logic                  n_pv_high_fault;
    logic                  n_bus_low_fault;
    logic [VOLT_W-1:0]     lane_max;
    logic [VOLT_W-1:0]     peak;
    logic                  take;

    // the output register frees up when empty or being read
    assign take = !r_out_valid || i_m_tready;

    // running maximum over the lane registers
    always_comb begin
        lane_max = '0;
        for (int k = 0; k < PV_CHANNELS; k++) begin
            if (i_lane_value[k] > lane_max) begin
                lane_max = i_lane_value[k];
            end
        end
    end

    assign peak = (i_stage.req_type == REQ_PV) ? lane_max : '0;

    // next state of counters and flags for the word in the lane stage
    always_comb begin
        n_low_count     = r_low_count;
        n_high_count    = r_high_count;
        n_normal_count  = r_normal_count;
        n_bus_count     = r_bus_count;
        n_pv_low_fault  = r_pv_low_fault;
        n_pv_high_fault = r_pv_high_fault;
        n_bus_low_fault = r_bus_low_fault;
        if (i_stage.req_type == REQ_PV) begin
            if (peak < i_limits.pv_low) begin
                n_low_count    = r_low_count + 2'd1;
                n_normal_count = '0;
                if (n_low_count >= LOW_HIGH_TRIP) begin
                    n_pv_low_fault  = 1'b1;
                    n_pv_high_fault = 1'b0;
                    n_low_count     = '0;
                end
            end else if (peak > i_limits.pv_high) begin
                n_high_count   = r_high_count + 2'd1;
                n_normal_count = '0;
                if (n_high_count >= LOW_HIGH_TRIP) begin
                    n_pv_high_fault = 1'b1;
                    n_pv_low_fault  = 1'b0;
                    n_high_count    = '0;
                end
            end else if (r_pv_low_fault || r_pv_high_fault) begin
                // normal counter saturates at its clear point
                if (r_normal_count < NORMAL_CLEAR) begin
                    n_normal_count = r_normal_count + 8'd1;
                end
                if (n_normal_count >= NORMAL_CLEAR) begin
                    n_low_count     = '0;
                    n_high_count    = '0;
                    n_pv_low_fault  = 1'b0;
                    n_pv_high_fault = 1'b0;
                end
            end
        end else begin
            if (i_stage.bus_volt < i_limits.bus_low) begin
                n_bus_count = r_bus_count + 7'd1;
                if (n_bus_count >= BUS_TRIP) begin
                    n_bus_low_fault = 1'b1;
                    n_bus_count     = '0;
                end
            end else begin
                n_bus_count = '0;
            end
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_count     <= '0;
            r_high_count    <= '0;
            r_normal_count  <= '0;
            r_bus_count     <= '0;
            r_pv_low_fault  <= 1'b0;
            r_pv_high_fault <= 1'b0;
            r_bus_low_fault <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_data      <= '0;
        end else if (take) begin
            r_out_valid <= i_stage.valid;
            if (i_stage.valid) begin
                r_low_count     <= n_low_count;
                r_high_count    <= n_high_count;
                r_normal_count  <= n_normal_count;
                r_bus_count     <= n_bus_count;
                r_pv_low_fault  <= n_pv_low_fault;
                r_pv_high_fault <= n_pv_high_fault;
                r_bus_low_fault <= n_bus_low_fault;
                r_out_data      <= OUT_DATA_W'({peak, n_bus_low_fault,
                                                n_pv_high_fault, n_pv_low_fault});
            end
        end
    end

    assign o_take     = take;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- design/pv_bus_voltage_fault_monitor_top.sv -----
// top level of the pv bus voltage fault monitor: config registers, lanes and merge stage
//
// Usage:
//   Input stream (s side): one word per check. tuser selects the check, zero for a
//   pv check on the sample lanes, one for a bus check on bus_volt.
//   Output stream (m side): one word per input word, in order, with the three
//   fault flags after that check and the pv peak (zero for bus checks).
//   Config channel: index 0 pv channel count, 1 pv low limit, 2 pv high limit,
//   3 bus low limit; other indexes are ignored. Always ready; write only while
//   the block holds no word in flight.
//   Path: an accepted word is held in the lane stage, then in the output register.
//   Throughput: one word per cycle unless stalled, set by the single merge stage
//   that updates the debounce counters; the lanes run side by side on the pv samples.
//   Reset (synchronous, active low): limits and channel count take their reset
//   values, all counters and fault flags clear, both stages empty.
//   Stall: the output register holds its word while tready is low; the lane
//   stage takes one more word, after which s tready drops until the output moves.
module pv_bus_voltage_fault_monitor_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // s side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata from bit 0: pv_volt_0, pv_volt_1, pv_volt_2, pv_volt_3, bus_volt
    input  logic [pvfm_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser from bit 0: req_type
    input  logic [0:0]                        i_s_tuser,
    // m side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata from bit 0: pv_low_fault, pv_high_fault, bus_low_fault, pv_peak, zero pad
    output logic [pvfm_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pvfm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pvfm_pkg::VOLT_W-1:0]       i_cfg_data
);
    import pvfm_pkg::*;

    logic [CNT_W-1:0]  r_pv_count;
    t_limits           r_limits;
    t_stage            r_stage;

    logic                                  take;
    logic                                  s_ready;
    logic [PV_CHANNELS-1:0]                lane_en;
    logic [PV_CHANNELS-1:0][VOLT_W-1:0]    lane_value;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv_count       <= PV_COUNT_RST;
            r_limits.pv_low  <= PV_LOW_RST;
            r_limits.pv_high <= PV_HIGH_RST;
            r_limits.bus_low <= BUS_LOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PV_COUNT: r_pv_count       <= i_cfg_data[CNT_W-1:0];
                REG_PV_LOW:   r_limits.pv_low  <= i_cfg_data;
                REG_PV_HIGH:  r_limits.pv_high <= i_cfg_data;
                REG_BUS_LOW:  r_limits.bus_low <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // lane stage moves when empty or when the merge stage takes it
    assign s_ready = !r_stage.valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (s_ready) begin
            r_stage.valid    <= i_s_tvalid;
            r_stage.req_type <= i_s_tuser[0];
            r_stage.bus_volt <= i_s_tdata[PV_CHANNELS*VOLT_W +: VOLT_W];
        end
    end

    // one lane per pv channel, enabled below the configured count
    for (genvar k = 0; k < PV_CHANNELS; k++) begin : g_lane
        assign lane_en[k] = ((CNT_W + 1)'(k) < {1'b0, r_pv_count});

        pvfm_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (s_ready),
            .i_enable (lane_en[k]),
            .i_sample (i_s_tdata[k*VOLT_W +: VOLT_W]),
            .o_value  (lane_value[k])
        );
    end

    pvfm_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (r_stage),
        .i_lane_value (lane_value),
        .i_limits     (r_limits),
        .i_m_tready   (i_m_tready),
        .o_take       (take),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata)
    );

    assign o_s_tready = s_ready;

endmodule

// ----- design/pvfm_checker.sv -----
// port level checks of the pv bus voltage fault monitor, bound to the top level
module pvfm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [pvfm_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import pvfm_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // low and high pv faults exclude each other
    a_pv_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("pv low and high fault both set");

    // the bus fault stays latched until reset
    a_bus_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tdata[2] |=> o_m_tdata[2])
        else $error("bus fault cleared without reset");

    // an accepted word with the output free passes the lane stage to the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid && i_m_tready
        |=> ##1 o_m_tvalid)
        else $error("result missing after accepted word");

    // padding bits above the fields stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata >> OUT_FIELD_W) == '0)
        else $error("nonzero padding in output word");

endmodule

bind pv_bus_voltage_fault_monitor_top pvfm_checker u_pvfm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- tb/sv/tb_top.sv -----
// self-checking testbench of the pv bus voltage fault monitor: stream driver, sink and scoreboard
module tb_top;
    import pvfm_pkg::*;

    // one check word as it travels on the input tdata
    typedef struct packed {
        logic [VOLT_W-1:0]                   bus_volt;
        logic [PV_CHANNELS-1:0][VOLT_W-1:0]  pv_volt;
    } t_check;

    // one status word as it travels on the output tdata
    typedef struct packed {
        logic [OUT_DATA_W-OUT_FIELD_W-1:0]   pad;
        logic [VOLT_W-1:0]                   pv_peak;
        logic                                bus_low_fault;
        logic                                pv_high_fault;
        logic                                pv_low_fault;
    } t_status;

    // what a generated check word aims at
    typedef enum {
        GEN_PV_LOW,
        GEN_PV_HIGH,
        GEN_PV_NORMAL,
        GEN_BUS_LOW,
        GEN_BUS_OK,
        GEN_NOISE
    } t_sample_kind;

    // fault debounce predictor and expected status queue
    class fault_scoreboard;
        logic [CNT_W-1:0]  pv_count;
        logic [VOLT_W-1:0] pv_low;
        logic [VOLT_W-1:0] pv_high;
        logic [VOLT_W-1:0] bus_low;
        logic [1:0]        low_run;
        logic [1:0]        high_run;
        logic [7:0]        normal_run;
        logic [6:0]        bus_run;
        logic              flt_low;
        logic              flt_high;
        logic              flt_bus;
        t_status           status_q[$];
        int                errors;
        int                pv_checks;
        int                bus_checks;
        int                reg_writes;
        int                low_trips;
        int                high_trips;
        int                pv_clears;
        int                bus_latches;

        function new();
            pv_count   = PV_COUNT_RST;
            pv_low     = PV_LOW_RST;
            pv_high    = PV_HIGH_RST;
            bus_low    = BUS_LOW_RST;
            low_run    = '0;
            high_run   = '0;
            normal_run = '0;
            bus_run    = '0;
            flt_low    = 1'b0;
            flt_high   = 1'b0;
            flt_bus    = 1'b0;
            errors     = 0;
            pv_checks  = 0;
            bus_checks = 0;
            reg_writes = 0;
            low_trips  = 0;
            high_trips = 0;
            pv_clears  = 0;
            bus_latches = 0;
        endfunction

        // pv lanes taken into the peak, saturated to the lane count
        function int lanes();
            return (pv_count > PV_CHANNELS) ? PV_CHANNELS : int'(pv_count);
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // register write accepted on the config channel
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VOLT_W-1:0] data);
            reg_writes++;
            case (idx)
                REG_PV_COUNT: pv_count = data[CNT_W-1:0];
                REG_PV_LOW:   pv_low   = data;
                REG_PV_HIGH:  pv_high  = data;
                REG_BUS_LOW:  bus_low  = data;
                default: ;
            endcase
        endfunction

        // accepted check word: step the debounce state and queue the status
        function void note_check(logic req, t_check item);
            logic [VOLT_W-1:0] peak;
            t_status           st;
            peak = '0;
            if (req == REQ_PV) begin
                pv_checks++;
                for (int k = 0; k < lanes(); k++) begin
                    if (item.pv_volt[k] > peak) peak = item.pv_volt[k];
                end
                if (peak < pv_low) begin
                    low_run++;
                    if (low_run >= LOW_HIGH_TRIP) begin
                        flt_low  = 1'b1;
                        flt_high = 1'b0;
                        low_run  = '0;
                        low_trips++;
                    end
                    normal_run = '0;
                end else if (peak > pv_high) begin
                    high_run++;
                    if (high_run >= LOW_HIGH_TRIP) begin
                        flt_high = 1'b1;
                        flt_low  = 1'b0;
                        high_run = '0;
                        high_trips++;
                    end
                    normal_run = '0;
                end else if (flt_low || flt_high) begin
                    // normal run saturates at the clear count
                    if (normal_run < NORMAL_CLEAR) normal_run++;
                    if (normal_run >= NORMAL_CLEAR) begin
                        low_run  = '0;
                        high_run = '0;
                        flt_low  = 1'b0;
                        flt_high = 1'b0;
                        pv_clears++;
                    end
                end
            end else begin
                bus_checks++;
                if (item.bus_volt < bus_low) begin
                    bus_run++;
                    if (bus_run >= BUS_TRIP) begin
                        flt_bus = 1'b1;
                        bus_run = '0;
                        bus_latches++;
                    end
                end else begin
                    bus_run = '0;
                end
            end
            st.pad           = '0;
            st.pv_peak       = peak;
            st.bus_low_fault = flt_bus;
            st.pv_high_fault = flt_high;
            st.pv_low_fault  = flt_low;
            status_q.push_back(st);
        endfunction

        function void check_field(string name, int exp_val, int got_val);
            if (exp_val != got_val) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
                errors++;
            end
        endfunction

        // status word seen on the output, compared with the oldest expectation
        function void check_status(t_status got);
            t_status exp_st;
            if (status_q.size() == 0) begin
                $error("status word 0x%0h arrived with no check outstanding", got);
                errors++;
                return;
            end
            exp_st = status_q.pop_front();
            check_field("pv_low_fault", exp_st.pv_low_fault, got.pv_low_fault);
            check_field("pv_high_fault", exp_st.pv_high_fault, got.pv_high_fault);
            check_field("bus_low_fault", exp_st.bus_low_fault, got.bus_low_fault);
            check_field("pv_peak", exp_st.pv_peak, got.pv_peak);
            check_field("pad", exp_st.pad, got.pad);
        endfunction

        function void summary();
            $display("covered %0d pv checks, %0d bus checks, %0d register writes",
                     pv_checks, bus_checks, reg_writes);
            $display("low trips %0d, high trips %0d, clears after normal run %0d, bus latches %0d",
                     low_trips, high_trips, pv_clears, bus_latches);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata;
    logic [0:0]             i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [VOLT_W-1:0]      i_cfg_data;

    fault_scoreboard sb = new();
    bit              idle_on;
    int              rnd_items;

    pv_bus_voltage_fault_monitor_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    // output sink with random stall bursts
    initial begin : sink
        int burst;
        i_m_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(5, 0) == 0) begin
                burst = $urandom_range(11, 1);
                i_m_tready = 1'b0;
                repeat (burst) @(negedge i_clk);
                i_m_tready = 1'b1;
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_status(t_status'(o_m_tdata));
        end
    end

    // drive one check word, with an optional gap ahead of it
    task automatic send_item(input logic req, input t_check item);
        int gap;
        if (idle_on && $urandom_range(4, 0) == 0) begin
            gap = $urandom_range(11, 1);
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = item;
        i_s_tuser  = req;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_check(req, item);
    endtask

    // config register write through its own handshake
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VOLT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // hold the sender until every status word is back and the pipe is empty
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_check pack_volts(input logic [VOLT_W-1:0] v0, v1, v2, v3, bv);
        t_check item;
        item.pv_volt[0] = v0;
        item.pv_volt[1] = v1;
        item.pv_volt[2] = v2;
        item.pv_volt[3] = v3;
        item.bus_volt   = bv;
        return item;
    endfunction

    // build a word aimed at one debounce branch under the current limits
    task automatic send_kind(input t_sample_kind kind);
        t_check item;
        logic   req;
        int     n;
        int     j;
        n   = sb.lanes();
        req = REQ_PV;
        item.bus_volt = VOLT_W'($urandom);
        for (j = 0; j < PV_CHANNELS; j++) item.pv_volt[j] = VOLT_W'($urandom);
        case (kind)
            GEN_PV_LOW: begin
                if (sb.pv_low != 0) begin
                    for (j = 0; j < n; j++)
                        item.pv_volt[j] = VOLT_W'($urandom_range(int'(sb.pv_low) - 1, 0));
                end
            end
            GEN_PV_HIGH: begin
                if (sb.pv_high != 16'hFFFF && n > 0) begin
                    j = $urandom_range(n - 1, 0);
                    item.pv_volt[j] = VOLT_W'($urandom_range(65535, int'(sb.pv_high) + 1));
                end
            end
            GEN_PV_NORMAL: begin
                if (sb.pv_low <= sb.pv_high) begin
                    for (j = 0; j < n; j++)
                        item.pv_volt[j] = VOLT_W'($urandom_range(int'(sb.pv_high),
                                                                 int'(sb.pv_low)));
                end
            end
            GEN_BUS_LOW: begin
                req = REQ_BUS;
                if (sb.bus_low != 0)
                    item.bus_volt = VOLT_W'($urandom_range(int'(sb.bus_low) - 1, 0));
            end
            GEN_BUS_OK: begin
                req = REQ_BUS;
                item.bus_volt = VOLT_W'($urandom_range(65535, int'(sb.bus_low)));
            end
            default: begin
                req = 1'($urandom_range(1, 0));
            end
        endcase
        rnd_items++;
        send_item(req, item);
    endtask

    // limits and lane count for one random phase, extremes included
    task automatic setup_phase();
        int lo;
        int hi;
        case ($urandom_range(5, 0))
            3: begin lo = 0;     hi = 65535; end
            4: begin lo = 65535; hi = 0;     end
            5: begin lo = $urandom_range(65535, 0); hi = $urandom_range(65535, 0); end
            default: begin
                lo = $urandom_range(20000, 1);
                hi = $urandom_range(65534, lo + 1000);
            end
        endcase
        cfg_write(REG_PV_LOW, VOLT_W'(lo));
        cfg_write(REG_PV_HIGH, VOLT_W'(hi));
        cfg_write(REG_PV_COUNT,
                  VOLT_W'(($urandom_range(2, 0) == 0) ? $urandom_range(7, 0) : 4));
        case ($urandom_range(3, 0))
            0: cfg_write(REG_BUS_LOW, 16'h0000);
            1: cfg_write(REG_BUS_LOW, 16'hFFFF);
            default: cfg_write(REG_BUS_LOW, VOLT_W'($urandom));
        endcase
        if ($urandom_range(2, 0) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(7, 4)), VOLT_W'($urandom));
    endtask

    // stimulus
    initial begin : stimulus
        int           phase;
        int           len;
        int           burst;
        bit           phase_idle;
        t_sample_kind kind;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_on     = 1'b0;
        rnd_items   = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset limits: nothing low or high, field extremes, bus word carries zero peak
        idle_on = 1'b1;
        send_item(REQ_PV, pack_volts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(REQ_PV, pack_volts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(REQ_BUS, pack_volts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_item(REQ_BUS, pack_volts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));

        // zero lanes gives a zero peak
        settle();
        cfg_write(REG_PV_COUNT, 16'd0);
        send_item(REQ_PV, pack_volts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));

        // lane count above the lane total saturates, unknown indexes are dropped
        settle();
        cfg_write(REG_PV_COUNT, 16'd7);
        cfg_write(3'd5, 16'h1234);
        cfg_write(3'd7, 16'hFFFF);
        send_item(REQ_PV, pack_volts(16'h0001, 16'h0002, 16'h0003, 16'hABCD, 16'h0000));

        // low trip, high trip taking over, split low run across a normal word
        settle();
        cfg_write(REG_PV_COUNT, 16'd4);
        cfg_write(REG_PV_LOW, 16'h1000);
        cfg_write(REG_PV_HIGH, 16'hE000);
        cfg_write(REG_BUS_LOW, 16'h8000);
        repeat (2) send_item(REQ_PV, pack_volts(16'h0100, 16'h0FFF, 16'h0000, 16'h0800, 16'h0));
        repeat (2) send_item(REQ_PV, pack_volts(16'h0100, 16'hFFFF, 16'h0000, 16'h0800, 16'h0));
        send_item(REQ_PV, pack_volts(16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0000));
        send_item(REQ_PV, pack_volts(16'h5000, 16'h1000, 16'hE000, 16'h2000, 16'h0000));
        send_item(REQ_PV, pack_volts(16'h0FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        repeat (3) send_item(REQ_BUS, pack_volts(16'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF));
        send_item(REQ_BUS, pack_volts(16'h0, 16'h0, 16'h0, 16'h0, 16'h8000));

        // random phases, each under its own settings
        phase = 0;
        while (rnd_items < 500) begin
            settle();
            phase_idle = ($urandom_range(3, 0) != 0);
            idle_on    = phase_idle && (rnd_items < 430);
            if (phase == 2) begin
                // trip a fault, then a normal run long enough to clear it,
                // with enough low bus samples between to latch the bus fault
                cfg_write(REG_PV_COUNT, 16'd4);
                cfg_write(REG_PV_LOW, 16'h2000);
                cfg_write(REG_PV_HIGH, 16'hD000);
                cfg_write(REG_BUS_LOW, 16'h9000);
                repeat (2) send_kind(GEN_PV_LOW);
                repeat (252) begin
                    send_kind(GEN_PV_NORMAL);
                    if ($urandom_range(1, 0) == 1) send_kind(GEN_BUS_LOW);
                end
            end else begin
                setup_phase();
                len = 0;
                while (len < 60 && rnd_items < 500) begin
                    idle_on = phase_idle && (rnd_items < 430);
                    case ($urandom_range(5, 0))
                        0: begin kind = GEN_PV_LOW;    burst = $urandom_range(4, 1);  end
                        1: begin kind = GEN_PV_HIGH;   burst = $urandom_range(4, 1);  end
                        2: begin kind = GEN_PV_NORMAL; burst = $urandom_range(30, 1); end
                        3: begin kind = GEN_BUS_LOW;   burst = $urandom_range(20, 1); end
                        4: begin kind = GEN_BUS_OK;    burst = $urandom_range(3, 1);  end
                        default: begin kind = GEN_NOISE; burst = $urandom_range(5, 1); end
                    endcase
                    repeat (burst) send_kind(kind);
                    len += burst;
                end
            end
            phase++;
        end

        // drain and report
        idle_on = 1'b0;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        sb.summary();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
